>>> hw/rtl/ezp_pkg.sv
// Package for the ZXZ Euler-angle projection matrix block.
// Holds angle constants, divisor reciprocals, pipeline latencies and shared types.
// No dependencies.
package ezp_pkg;

   // Angle units are 1/64 degree.
   localparam int FULL_TURN    = 23040;
   localparam int QUARTER_TURN = 5760;
   localparam int EIGHTH_TURN  = 2880;
   localparam int RAD_PER_UNIT = 292818;
   localparam int ONE_Q14      = 16384;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // Number of paired Horner steps in the sine/cosine pipeline.
   localparam int STEPS = 5;

   // Latencies in register stages.
   localparam int SC_LAT    = 15;
   localparam int MAT_LAT   = 3;
   localparam int TR_LAT    = 3;
   localparam int TOTAL_LAT = SC_LAT + MAT_LAT + TR_LAT;

   // Exact division by a constant k for 30-bit dividends:
   // q = (p * ceil(2^(30+l) / k)) >> (30 + l), with 2^l >= k.
   localparam int COS_L [STEPS] = '{7, 6, 5, 4, 1};
   localparam int SIN_L [STEPS] = '{7, 6, 5, 3, 0};
   localparam longint unsigned COS_M [STEPS] = '{
      ((64'd1 << 37) + 64'd89) / 64'd90,
      ((64'd1 << 36) + 64'd55) / 64'd56,
      ((64'd1 << 35) + 64'd29) / 64'd30,
      ((64'd1 << 34) + 64'd11) / 64'd12,
      ((64'd1 << 31) + 64'd1) / 64'd2
   };
   localparam longint unsigned SIN_M [STEPS] = '{
      ((64'd1 << 37) + 64'd71) / 64'd72,
      ((64'd1 << 36) + 64'd41) / 64'd42,
      ((64'd1 << 35) + 64'd19) / 64'd20,
      ((64'd1 << 33) + 64'd5) / 64'd6,
      64'd0
   };

   // Sine and cosine of one angle, signed Q14.
   typedef struct packed {
      logic signed [15:0] sin_v;
      logic signed [15:0] cos_v;
   } trig_type;

   // Rotation entries, row then column, each signed Q14.
   typedef logic [2:0][2:0][15:0] rot_type;

endpackage

>>> hw/rtl/ezp_sincos.sv
// Pipelined sine and cosine of one angle in 1/64 degree, Q14 results.
// Range reduction, then paired Taylor/Horner steps with constant dividers.
// Depends on ezp_pkg.
module ezp_sincos (
   input  logic                clock,
   input  logic signed [15:0]  angle,
   output ezp_pkg::trig_type   trig
);
   import ezp_pkg::*;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        swap;
   } side_type;

   // Upper Q30 bits of a Q30 by Q30 product.
   function automatic logic [29:0] mul_q30(logic [29:0] a, logic [30:0] b);
      logic [60:0] p;
      p = 61'(a) * 61'(b);
      return p[59:30];
   endfunction

   // Quotient by reciprocal multiplication.
   function automatic logic [29:0] div_recip(logic [29:0] p, logic [30:0] m, int l);
      logic [60:0] t;
      t = 61'(p) * 61'(m);
      return 30'(t >> (30 + l));
   endfunction

   logic [14:0] a_ff, a_in;
   logic [11:0] r_ff, r_in;
   logic [1:0]  quad2_ff, quad2_in, quad3_ff;
   logic        swap2_ff, swap2_in, swap3_ff;
   logic [29:0] x_ff, x_in;
   logic [30:0] xprod;
   logic [59:0] xx;
   side_type    side_ff [0:2*STEPS];
   logic [29:0] cp_ff [0:STEPS-1];
   logic [29:0] cq_ff [0:STEPS-1];
   logic [29:0] sp_ff [0:STEPS-1];
   logic [29:0] sq_ff [0:STEPS-1];
   logic [30:0] ct [0:STEPS];
   logic [30:0] st [0:STEPS-1];
   trig_type    trig_ff, trig_in;

   // Reduce the angle into one full turn.
   always_comb begin
      logic signed [17:0] vs;
      logic [16:0]        v;
      vs = 18'(angle) + 18'sd46080;
      v  = vs[16:0];
      if (v >= 17'(3 * FULL_TURN)) begin
         a_in = 15'(v - 17'(3 * FULL_TURN));
      end else if (v >= 17'(2 * FULL_TURN)) begin
         a_in = 15'(v - 17'(2 * FULL_TURN));
      end else if (v >= 17'(FULL_TURN)) begin
         a_in = 15'(v - 17'(FULL_TURN));
      end else begin
         a_in = v[14:0];
      end
   end

   // Split into quadrant and remainder, folding the upper half of each quadrant.
   always_comb begin
      logic [14:0] r;
      if (a_ff >= 15'(3 * QUARTER_TURN)) begin
         quad2_in = 2'd3;
         r        = a_ff - 15'(3 * QUARTER_TURN);
      end else if (a_ff >= 15'(2 * QUARTER_TURN)) begin
         quad2_in = 2'd2;
         r        = a_ff - 15'(2 * QUARTER_TURN);
      end else if (a_ff >= 15'(QUARTER_TURN)) begin
         quad2_in = 2'd1;
         r        = a_ff - 15'(QUARTER_TURN);
      end else begin
         quad2_in = 2'd0;
         r        = a_ff;
      end
      swap2_in = (r > 15'(EIGHTH_TURN));
      r_in     = swap2_in ? 12'(15'(QUARTER_TURN) - r) : r[11:0];
   end

   // Radians in Q30 and its square.
   assign xprod = 31'(r_ff) * 31'(RAD_PER_UNIT);
   assign x_in  = xprod[29:0];
   assign xx    = 60'(x_ff) * 60'(x_ff);

   // Horner terms entering each step.
   always_comb begin
      ct[0] = ONE_Q30;
      st[0] = ONE_Q30;
      for (int j = 0; j < STEPS; j++) begin
         ct[j+1] = ONE_Q30 - {1'b0, cq_ff[j]};
      end
      for (int j = 0; j < STEPS - 1; j++) begin
         st[j+1] = ONE_Q30 - {1'b0, sq_ff[j]};
      end
   end

   // Final scaling to Q14 and quadrant signs.
   always_comb begin
      logic [30:0] tc;
      logic [31:0] sr, cr;
      logic signed [15:0] s, c, t;
      tc = ct[STEPS];
      sr = 32'(sq_ff[STEPS-1]) + 32'h8000;
      cr = 32'(tc) + 32'h8000;
      s  = 16'(sr[31:16]);
      c  = 16'(cr[31:16]);
      if (side_ff[2*STEPS].swap) begin
         t = s;
         s = c;
         c = t;
      end
      case (side_ff[2*STEPS].quad)
         2'd0: begin
            trig_in.sin_v = s;
            trig_in.cos_v = c;
         end
         2'd1: begin
            trig_in.sin_v = c;
            trig_in.cos_v = -s;
         end
         2'd2: begin
            trig_in.sin_v = -s;
            trig_in.cos_v = -c;
         end
         default: begin
            trig_in.sin_v = -c;
            trig_in.cos_v = s;
         end
      endcase
   end

   // Pipeline registers; the stream never stalls, so every stage advances.
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      r_ff        <= r_in;
      quad2_ff    <= quad2_in;
      swap2_ff    <= swap2_in;
      x_ff        <= x_in;
      quad3_ff    <= quad2_ff;
      swap3_ff    <= swap2_ff;
      side_ff[0]  <= '{x: x_ff, x2: xx[59:30], quad: quad3_ff, swap: swap3_ff};
      for (int k = 1; k <= 2 * STEPS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      for (int j = 0; j < STEPS; j++) begin
         cp_ff[j] <= mul_q30(side_ff[2*j].x2, ct[j]);
         cq_ff[j] <= div_recip(cp_ff[j], 31'(COS_M[j]), COS_L[j]);
         if (j < STEPS - 1) begin
            sp_ff[j] <= mul_q30(side_ff[2*j].x2, st[j]);
            sq_ff[j] <= div_recip(sp_ff[j], 31'(SIN_M[j]), SIN_L[j]);
         end else begin
            // Last sine step multiplies by x instead of dividing.
            sp_ff[j] <= mul_q30(side_ff[2*j].x, st[j]);
            sq_ff[j] <= sp_ff[j];
         end
      end
      trig_ff <= trig_in;
   end

   assign trig = trig_ff;

endmodule

>>> hw/rtl/ezp_matrix.sv
// Rotation matrix Rz(chi)*Rx(theta)*Rz(phi) from Q14 sines and cosines.
// Three stages: pair products, triple products and sums, rounding and clamping.
// Depends on ezp_pkg.
module ezp_matrix (
   input  logic               clock,
   input  ezp_pkg::trig_type  phi,
   input  ezp_pkg::trig_type  theta,
   input  ezp_pkg::trig_type  chi,
   output ezp_pkg::rot_type   rot
);
   import ezp_pkg::*;

   // floor(v / 2^n + 1/2), clamped to one in Q14.
   function automatic logic [15:0] round_clamp(logic signed [47:0] v, int n);
      logic signed [47:0] t;
      t = (v + (48'sd1 <<< (n - 1))) >>> n;
      if (t > 48'sd16384) begin
         t = 48'sd16384;
      end else if (t < -48'sd16384) begin
         t = -48'sd16384;
      end
      return t[15:0];
   endfunction

   logic signed [15:0] sp, cp, st, ct, sc, cc;
   assign sp = phi.sin_v;
   assign cp = phi.cos_v;
   assign st = theta.sin_v;
   assign ct = theta.cos_v;
   assign sc = chi.sin_v;
   assign cc = chi.cos_v;

   // Stage one: pair products.
   logic signed [31:0] cccp_ff, scct_ff, ccsp_ff, sccp_ff, ccct_ff, scsp_ff;
   logic signed [31:0] scst_ff, ccst_ff, stsp_ff, stcp_ff;
   logic signed [15:0] sp1_ff, cp1_ff, ct1_ff;

   // Stage two: Q42 triple sums and Q28 pair terms.
   logic signed [47:0] t00_ff, t01_ff, t10_ff, t11_ff, t00_in, t01_in, t10_in, t11_in;
   logic signed [47:0] e02_ff, e12_ff, e20_ff, e21_ff;
   logic signed [15:0] ct2_ff;

   rot_type rot_ff, rot_in;

   always_comb begin
      logic signed [47:0] a, b;
      a      = scct_ff * sp1_ff;
      t00_in = (48'(cccp_ff) <<< 14) - a;
      b      = scct_ff * cp1_ff;
      t01_in = (48'(ccsp_ff) <<< 14) + b;
      a      = ccct_ff * sp1_ff;
      t10_in = -(48'(sccp_ff) <<< 14) - a;
      b      = ccct_ff * cp1_ff;
      t11_in = -(48'(scsp_ff) <<< 14) + b;
   end

   // Stage three: round once to Q14 and clamp.
   always_comb begin
      logic signed [15:0] c22;
      rot_in[0][0] = round_clamp(t00_ff, 28);
      rot_in[0][1] = round_clamp(t01_ff, 28);
      rot_in[0][2] = round_clamp(e02_ff, 14);
      rot_in[1][0] = round_clamp(t10_ff, 28);
      rot_in[1][1] = round_clamp(t11_ff, 28);
      rot_in[1][2] = round_clamp(e12_ff, 14);
      rot_in[2][0] = round_clamp(e20_ff, 14);
      rot_in[2][1] = round_clamp(e21_ff, 14);
      c22 = ct2_ff;
      if (c22 > 16'sd16384) begin
         c22 = 16'sd16384;
      end else if (c22 < -16'sd16384) begin
         c22 = -16'sd16384;
      end
      rot_in[2][2] = c22;
   end

   always_ff @(posedge clock) begin
      cccp_ff <= cc * cp;
      scct_ff <= sc * ct;
      ccsp_ff <= cc * sp;
      sccp_ff <= sc * cp;
      ccct_ff <= cc * ct;
      scsp_ff <= sc * sp;
      scst_ff <= sc * st;
      ccst_ff <= cc * st;
      stsp_ff <= st * sp;
      stcp_ff <= st * cp;
      sp1_ff  <= sp;
      cp1_ff  <= cp;
      ct1_ff  <= ct;
      t00_ff  <= t00_in;
      t01_ff  <= t01_in;
      t10_ff  <= t10_in;
      t11_ff  <= t11_in;
      e02_ff  <= 48'(scst_ff);
      e12_ff  <= 48'(ccst_ff);
      e20_ff  <= 48'(stsp_ff);
      e21_ff  <= -48'(stcp_ff);
      ct2_ff  <= ct1_ff;
      rot_ff  <= rot_in;
   end

   assign rot = rot_ff;

endmodule

>>> hw/rtl/ezp_shift.sv
// Translation column: centre minus the rotated half volume, saturated Q24.8.
// Three stages: size products, row sums with rounding, subtraction and saturation.
// Depends on ezp_pkg.
module ezp_shift (
   input  logic                clock,
   input  ezp_pkg::rot_type    rot,
   input  logic signed [31:0]  centre_x,
   input  logic signed [31:0]  centre_y,
   input  logic [12:0]         volume_width,
   input  logic [12:0]         volume_height,
   input  logic [12:0]         volume_depth,
   output ezp_pkg::rot_type    rot_out,
   output logic signed [31:0]  shift_x,
   output logic signed [31:0]  shift_y,
   output logic signed [31:0]  shift_z
);
   import ezp_pkg::*;

   logic signed [13:0] size [0:2];
   assign size[0] = {1'b0, volume_width};
   assign size[1] = {1'b0, volume_height};
   assign size[2] = {1'b0, volume_depth};

   logic signed [29:0] prod_ff [0:2][0:2];
   logic signed [31:0] off_ff [0:2];
   logic signed [31:0] off_in [0:2];
   logic signed [31:0] sh_ff [0:2];
   logic signed [31:0] sh_in [0:2];
   logic signed [31:0] cx1_ff, cy1_ff, cx2_ff, cy2_ff;
   rot_type            rot1_ff, rot2_ff, rot3_ff;

   // Row sums, rounded from Q15 to Q8.
   always_comb begin
      logic signed [31:0] s;
      for (int i = 0; i < 3; i++) begin
         s = 32'(prod_ff[i][0]) + 32'(prod_ff[i][1]) + 32'(prod_ff[i][2]);
         off_in[i] = (s + 32'sd64) >>> 7;
      end
   end

   // Centre minus offset, saturated to 32 bits.
   always_comb begin
      logic signed [33:0] d;
      logic signed [31:0] c;
      for (int i = 0; i < 3; i++) begin
         c = (i == 0) ? cx2_ff : ((i == 1) ? cy2_ff : 32'sd0);
         d = 34'(c) - 34'(off_ff[i]);
         if (d > 34'sd2147483647) begin
            sh_in[i] = 32'sh7FFF_FFFF;
         end else if (d < -34'sd2147483648) begin
            sh_in[i] = 32'sh8000_0000;
         end else begin
            sh_in[i] = d[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= $signed(rot[i][j]) * size[j];
         end
         off_ff[i] <= off_in[i];
         sh_ff[i]  <= sh_in[i];
      end
      cx1_ff  <= centre_x;
      cy1_ff  <= centre_y;
      cx2_ff  <= cx1_ff;
      cy2_ff  <= cy1_ff;
      rot1_ff <= rot;
      rot2_ff <= rot1_ff;
      rot3_ff <= rot2_ff;
   end

   assign rot_out = rot3_ff;
   assign shift_x = sh_ff[0];
   assign shift_y = sh_ff[1];
   assign shift_z = sh_ff[2];

endmodule

>>> hw/rtl/euler_zxz_projection_matrix.sv
// ZXZ Euler-angle projection matrix, top level.
// Instantiates three ezp_sincos units, ezp_matrix and ezp_shift; uses ezp_pkg.
//
// Usage:
//   An item (three angles in 1/64 degree and a Q24.8 particle centre) is taken
//   on every clock edge where start is high; busy stays low, so one item can be
//   given in every cycle.
//   Each item yields one result: nine Q2.14 rotation entries and three saturated
//   Q24.8 translations, shown for one cycle with rsp_valid high.
//   Each item passes from the accepting edge through the sine/cosine pipeline
//   (range reduction and five Horner steps, each a multiply and, but for the
//   last sine step, a reciprocal multiply), then the matrix products and then
//   the translation. Throughput is one item per cycle.
//   The volume sizes come from the csr port (index 0 width, 1 height, 2 depth)
//   and should be written while no item is in flight.
//   Reset clears the item valid line and sets every volume size to 128.
//   The receiver cannot stall: each result must be taken in its cycle.
module euler_zxz_projection_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_first_z_angle,
   input  logic signed [15:0]  req_tilt_angle,
   input  logic signed [15:0]  req_second_z_angle,
   input  logic signed [31:0]  req_centre_x,
   input  logic signed [31:0]  req_centre_y,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_m00,
   output logic signed [15:0]  rsp_m01,
   output logic signed [15:0]  rsp_m02,
   output logic signed [31:0]  rsp_shift_x,
   output logic signed [15:0]  rsp_m10,
   output logic signed [15:0]  rsp_m11,
   output logic signed [15:0]  rsp_m12,
   output logic signed [31:0]  rsp_shift_y,
   output logic signed [15:0]  rsp_m20,
   output logic signed [15:0]  rsp_m21,
   output logic signed [15:0]  rsp_m22,
   output logic signed [31:0]  rsp_shift_z,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_write_data
);
   import ezp_pkg::*;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_DEPTH  = 2'd2,
      REG_NONE   = 2'd3
   } csr_index_type;

   logic [12:0] width_ff, height_ff, depth_ff;
   logic [TOTAL_LAT-1:0] valid_ff;
   logic signed [31:0] cx_ff [0:SC_LAT+MAT_LAT-1];
   logic signed [31:0] cy_ff [0:SC_LAT+MAT_LAT-1];
   trig_type phi, theta, chi;
   rot_type  rot, rot_out;

   assign busy = 1'b0;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd128;
         height_ff <= 13'd128;
         depth_ff  <= 13'd128;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_WIDTH:  width_ff  <= csr_write_data;
            REG_HEIGHT: height_ff <= csr_write_data;
            REG_DEPTH:  depth_ff  <= csr_write_data;
            default:    ;
         endcase
      end
   end

   // Item valid line alongside the data pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[TOTAL_LAT-2:0], start & ~busy};
      end
   end

   // Centres wait until the matrix is ready.
   always_ff @(posedge clock) begin
      cx_ff[0] <= req_centre_x;
      cy_ff[0] <= req_centre_y;
      for (int k = 1; k < SC_LAT + MAT_LAT; k++) begin
         cx_ff[k] <= cx_ff[k-1];
         cy_ff[k] <= cy_ff[k-1];
      end
   end

   ezp_sincos u_phi (
      .clock (clock),
      .angle (req_first_z_angle),
      .trig  (phi)
   );

   ezp_sincos u_theta (
      .clock (clock),
      .angle (req_tilt_angle),
      .trig  (theta)
   );

   ezp_sincos u_chi (
      .clock (clock),
      .angle (req_second_z_angle),
      .trig  (chi)
   );

   ezp_matrix u_matrix (
      .clock (clock),
      .phi   (phi),
      .theta (theta),
      .chi   (chi),
      .rot   (rot)
   );

   ezp_shift u_shift (
      .clock         (clock),
      .rot           (rot),
      .centre_x      (cx_ff[SC_LAT+MAT_LAT-1]),
      .centre_y      (cy_ff[SC_LAT+MAT_LAT-1]),
      .volume_width  (width_ff),
      .volume_height (height_ff),
      .volume_depth  (depth_ff),
      .rot_out       (rot_out),
      .shift_x       (rsp_shift_x),
      .shift_y       (rsp_shift_y),
      .shift_z       (rsp_shift_z)
   );

   assign rsp_valid = valid_ff[TOTAL_LAT-1];
   assign rsp_m00   = rot_out[0][0];
   assign rsp_m01   = rot_out[0][1];
   assign rsp_m02   = rot_out[0][2];
   assign rsp_m10   = rot_out[1][0];
   assign rsp_m11   = rot_out[1][1];
   assign rsp_m12   = rot_out[1][2];
   assign rsp_m20   = rot_out[2][0];
   assign rsp_m21   = rot_out[2][1];
   assign rsp_m22   = rot_out[2][2];

   // Every result follows an accepted item by exactly the pipeline latency.
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, TOTAL_LAT))
      else $error("result without a matching item");

   // Nothing leaves the pipeline right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // Entries m00 and m22 stay within one in Q14.
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m22 <= 16'sd16384 && rsp_m22 >= -16'sd16384 &&
                     rsp_m00 <= 16'sd16384 && rsp_m00 >= -16'sd16384))
      else $error("rotation entry out of range");

endmodule
